@@ rtl/core/lsac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared types, constants and tables of the LED strip animation controller.
// ----------------------------------------------------------------------------
package lsac_pkg;

  localparam int unsigned DefPixelCount  = 10;
  localparam int unsigned DefTailLength  = 6;
  localparam int unsigned FrameFifoDepth = 2;

  localparam int unsigned PixW  = 6;   // pixel position, strips up to 64
  localparam int unsigned FillW = 7;   // fill level 0..64
  localparam int unsigned ChanW = 8;
  localparam int unsigned TailW = 9;   // Q1.8, 256 = 1.0
  localparam int unsigned CfgW  = 8;

  localparam logic [CfgW-1:0] BrightnessReset = 8'd77;
  localparam logic [CfgW-1:0] HoldFramesReset = 8'd5;

  localparam logic [7:0] CmdPresetMax = 8'h03;
  localparam logic [7:0] CmdCustom    = 8'h10;
  localparam logic [7:0] CmdWaveR     = 8'h20;
  localparam logic [7:0] CmdWaveL     = 8'h21;
  localparam logic [7:0] CmdStatic    = 8'h22;
  localparam logic [7:0] CmdFillR     = 8'h30;
  localparam logic [7:0] CmdFillL     = 8'h31;

  typedef enum logic [1:0] {
    OP_BUTTON,
    OP_BYTE,
    OP_FRAME
  } op_e;

  typedef enum logic {
    CFG_BRIGHTNESS,
    CFG_HOLD_FRAMES
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_SOLID,
    MODE_WAVE_R,
    MODE_WAVE_L,
    MODE_FILL_R,
    MODE_FILL_L
  } mode_e;

  typedef struct packed {
    mode_e            mode;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } step_t;

  // Snapshot of the animation state that one frame is rendered from
  typedef struct packed {
    mode_e            mode;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [PixW-1:0]  head;
    logic [FillW-1:0] fill;
  } frame_t;

  function automatic step_t step_entry(logic [2:0] idx);
    step_t s;
    unique case (idx)
      3'd0:    s = '{MODE_SOLID,  8'd0,   8'd255, 8'd0};
      3'd1:    s = '{MODE_SOLID,  8'd255, 8'd0,   8'd0};
      3'd2:    s = '{MODE_SOLID,  8'd255, 8'd255, 8'd0};
      3'd3:    s = '{MODE_SOLID,  8'd128, 8'd0,   8'd128};
      3'd4:    s = '{MODE_WAVE_R, 8'd255, 8'd120, 8'd0};
      3'd5:    s = '{MODE_WAVE_L, 8'd255, 8'd120, 8'd0};
      3'd6:    s = '{MODE_FILL_R, 8'd255, 8'd120, 8'd0};
      default: s = '{MODE_FILL_L, 8'd255, 8'd120, 8'd0};
    endcase
    return s;
  endfunction

  // Returns {red, green, blue}
  function automatic logic [3*ChanW-1:0] preset_rgb(logic [1:0] sel);
    logic [3*ChanW-1:0] c;
    unique case (sel)
      2'd0:    c = {8'd255, 8'd0,   8'd0};
      2'd1:    c = {8'd0,   8'd255, 8'd0};
      2'd2:    c = {8'd255, 8'd255, 8'd0};
      default: c = {8'd128, 8'd0,   8'd128};
    endcase
    return c;
  endfunction

  function automatic logic [TailW-1:0] tail_q8(logic [3:0] ofs);
    logic [TailW-1:0] t;
    unique case (ofs)
      4'd0:    t = 9'd256;
      4'd1:    t = 9'd179;
      4'd2:    t = 9'd128;
      4'd3:    t = 9'd77;
      4'd4:    t = 9'd51;
      4'd5:    t = 9'd26;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/lsac_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsac_front
// Accepts items, runs the button stepper and command parser, keeps the
// animation state and queues one frame snapshot per frame tick.
// ----------------------------------------------------------------------------
module lsac_front #(
  parameter int unsigned PixelCount = lsac_pkg::DefPixelCount
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  operation_i,
  input  logic                        button_level_i,
  input  logic [7:0]                  command_byte_i,
  input  logic [lsac_pkg::CfgW-1:0]   hold_frames_i,
  output logic                        frame_push_o,
  output lsac_pkg::frame_t            frame_o,
  input  logic                        frame_full_i
);
  import lsac_pkg::*;

  localparam logic [PixW-1:0]  LastPix  = PixW'(PixelCount - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(PixelCount);

  logic             accept;
  op_e              op;
  step_t            entry;

  mode_e            mode_q, mode_d;
  logic [2:0]       step_q, step_d;
  logic [ChanW-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [PixW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [CfgW-1:0]  hold_q, hold_d;
  logic             prev_btn_q, prev_btn_d;
  logic [1:0]       cmd_cnt_q, cmd_cnt_d;
  logic [7:0]       command_buffer_q [3];

  logic [2:0]       cnt_next;
  logic [7:0]       lead;
  logic             done;

  assign full   = frame_full_i;
  assign accept = push && !frame_full_i;
  assign op     = op_e'(operation_i);

  assign frame_o = '{mode_q, red_q, green_q, blue_q, head_q, fill_q};

  assign cnt_next = {1'b0, cmd_cnt_q} + 3'd1;
  assign lead     = (cmd_cnt_q == 2'd0) ? command_byte_i : command_buffer_q[0];
  assign entry    = step_entry(step_q + 3'd1);

  always_comb begin
    mode_d       = mode_q;
    step_d       = step_q;
    red_d        = red_q;
    green_d      = green_q;
    blue_d       = blue_q;
    head_d       = head_q;
    fill_d       = fill_q;
    hold_d       = hold_q;
    prev_btn_d   = prev_btn_q;
    cmd_cnt_d    = cmd_cnt_q;
    frame_push_o = 1'b0;
    done         = 1'b0;
    if (accept) begin
      case (op)
        OP_BUTTON: begin
          if (button_level_i && !prev_btn_q) begin
            step_d  = step_q + 3'd1;
            mode_d  = entry.mode;
            red_d   = entry.red;
            green_d = entry.green;
            blue_d  = entry.blue;
            head_d  = (entry.mode == MODE_WAVE_L) ? LastPix : '0;
            fill_d  = '0;
            hold_d  = '0;
          end
          prev_btn_d = button_level_i;
        end
        OP_BYTE: begin
          if (cnt_next == 3'd1) begin
            if (lead <= CmdPresetMax) begin
              {red_d, green_d, blue_d} = preset_rgb(lead[1:0]);
              mode_d = MODE_SOLID;
              done   = 1'b1;
            end else if (lead == CmdWaveR) begin
              mode_d = MODE_WAVE_R;
              head_d = '0;
              done   = 1'b1;
            end else if (lead == CmdWaveL) begin
              mode_d = MODE_WAVE_L;
              head_d = LastPix;
              done   = 1'b1;
            end else if (lead == CmdStatic) begin
              mode_d = MODE_SOLID;
              done   = 1'b1;
            end else if (lead == CmdFillR || lead == CmdFillL) begin
              mode_d = (lead == CmdFillR) ? MODE_FILL_R : MODE_FILL_L;
              fill_d = '0;
              hold_d = '0;
              done   = 1'b1;
            end
          end else if (cnt_next == 3'd4 && lead == CmdCustom) begin
            red_d   = command_buffer_q[1];
            green_d = command_buffer_q[2];
            blue_d  = command_byte_i;
            mode_d  = MODE_SOLID;
          end
          // drop whatever is buffered after four bytes
          if (cnt_next == 3'd4) begin
            done = 1'b1;
          end
          cmd_cnt_d = done ? 2'd0 : cnt_next[1:0];
        end
        OP_FRAME: begin
          frame_push_o = 1'b1;
          case (mode_q) inside
            MODE_WAVE_R: head_d = (head_q == LastPix) ? '0 : head_q + 1'b1;
            MODE_WAVE_L: head_d = (head_q == '0) ? LastPix : head_q - 1'b1;
            MODE_FILL_R, MODE_FILL_L: begin
              if (fill_q < FillFull) begin
                fill_d = fill_q + 1'b1;
              end else if (hold_q < hold_frames_i) begin
                hold_d = hold_q + 1'b1;
              end else begin
                fill_d = '0;
                hold_d = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_SOLID;
      step_q     <= '0;
      red_q      <= 8'd0;
      green_q    <= 8'd255;
      blue_q     <= 8'd0;
      head_q     <= '0;
      fill_q     <= '0;
      hold_q     <= '0;
      prev_btn_q <= 1'b0;
      cmd_cnt_q  <= '0;
    end else begin
      mode_q     <= mode_d;
      step_q     <= step_d;
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      hold_q     <= hold_d;
      prev_btn_q <= prev_btn_d;
      cmd_cnt_q  <= cmd_cnt_d;
    end
  end

  // The fourth byte is consumed in the cycle it arrives and never stored
  always_ff @(posedge clk_i) begin
    if (accept && op == OP_BYTE && cmd_cnt_q != 2'd3) begin
      command_buffer_q[cmd_cnt_q] <= command_byte_i;
    end
  end

endmodule

@@ rtl/core/lsac_frame_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsac_frame_fifo
// Short queue of frame snapshots between the front and the renderer.
// ----------------------------------------------------------------------------
module lsac_frame_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsac_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output lsac_pkg::frame_t data_o,
  output logic             empty_o
);
  import lsac_pkg::*;

  localparam int unsigned PtrW = (FrameFifoDepth > 1) ? $clog2(FrameFifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FrameFifoDepth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(FrameFifoDepth - 1);

  frame_t          mem_q [FrameFifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(FrameFifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastSlot) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastSlot) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/lsac_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsac_back
// Renders one frame snapshot into pixels: tail lookup, then scaling by the
// brightness-weighted color, into a two-entry result queue.
// ----------------------------------------------------------------------------
module lsac_back #(
  parameter int unsigned PixelCount = lsac_pkg::DefPixelCount,
  parameter int unsigned TailLength = lsac_pkg::DefTailLength
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      frame_valid_i,
  input  lsac_pkg::frame_t          frame_i,
  output logic                      frame_pop_o,
  input  logic [lsac_pkg::CfgW-1:0] brightness_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [23:0]               pixel_grb_o,
  output logic [5:0]                pixel_index_o,
  output logic                      last_o
);
  import lsac_pkg::*;

  localparam int unsigned OfsW   = PixW + 1;
  localparam int unsigned ProdW  = 2 * ChanW;
  localparam int unsigned ScaleW = ProdW + TailW;
  localparam logic [PixW-1:0]  LastPix  = PixW'(PixelCount - 1);
  localparam logic [OfsW-1:0]  PixN     = OfsW'(PixelCount);
  localparam logic [OfsW-1:0]  TailLen  = OfsW'(TailLength);
  localparam logic [FillW-1:0] FillFull = FillW'(PixelCount);

  frame_t             desc_q;
  logic [ProdW-1:0]   cb_red_q, cb_green_q, cb_blue_q;
  logic               busy_q;
  logic [PixW-1:0]    pix_q;

  logic               s1_valid_q;
  logic [TailW-1:0]   s1_tail_q;
  logic [PixW-1:0]    s1_idx_q;
  logic               s1_last_q;

  logic [23:0]        out_grb_q  [2];
  logic [PixW-1:0]    out_idx_q  [2];
  logic               out_last_q [2];
  logic               out_wptr_q, out_rptr_q;
  logic [1:0]         out_cnt_q;
  logic               out_full, out_push, out_pop;

  logic               issue;
  logic [OfsW-1:0]    ofs_raw, ofs;
  logic               lit;
  logic [TailW-1:0]   tail;
  logic [ScaleW-1:0]  sc_red, sc_green, sc_blue;

  // Hold the next frame until the last pixel has left the scaler stage
  assign frame_pop_o = !busy_q && frame_valid_i && (!s1_valid_q || out_push);

  assign out_full = (out_cnt_q == 2'd2);
  assign out_push = s1_valid_q && !out_full;
  assign out_pop  = pop && (out_cnt_q != 2'd0);
  assign issue    = busy_q && (!s1_valid_q || out_push);

  // Distance from the wave head, folded into 0..PixelCount-1
  always_comb begin
    if (desc_q.mode == MODE_WAVE_R) begin
      ofs_raw = OfsW'(desc_q.head) + PixN - OfsW'(pix_q);
    end else begin
      ofs_raw = OfsW'(pix_q) + PixN - OfsW'(desc_q.head);
    end
    ofs = (ofs_raw >= PixN) ? ofs_raw - PixN : ofs_raw;
    if (desc_q.mode == MODE_FILL_R) begin
      lit = FillW'(pix_q) < desc_q.fill;
    end else begin
      lit = (FillW'(pix_q) + desc_q.fill) >= FillFull;
    end
    case (desc_q.mode) inside
      MODE_WAVE_R, MODE_WAVE_L: tail = (ofs < TailLen) ? tail_q8(ofs[3:0]) : '0;
      MODE_FILL_R, MODE_FILL_L: tail = lit ? 9'd256 : '0;
      default:                  tail = 9'd256;
    endcase
  end

  assign sc_red   = ScaleW'(cb_red_q)   * ScaleW'(s1_tail_q);
  assign sc_green = ScaleW'(cb_green_q) * ScaleW'(s1_tail_q);
  assign sc_blue  = ScaleW'(cb_blue_q)  * ScaleW'(s1_tail_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pix_q      <= '0;
      s1_valid_q <= 1'b0;
      out_wptr_q <= 1'b0;
      out_rptr_q <= 1'b0;
      out_cnt_q  <= '0;
    end else begin
      if (frame_pop_o) begin
        busy_q <= 1'b1;
        pix_q  <= '0;
      end else if (issue) begin
        if (pix_q == LastPix) begin
          busy_q <= 1'b0;
        end else begin
          pix_q <= pix_q + 1'b1;
        end
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (out_push) begin
        s1_valid_q <= 1'b0;
      end
      if (out_push) begin
        out_wptr_q <= !out_wptr_q;
      end
      if (out_pop) begin
        out_rptr_q <= !out_rptr_q;
      end
      if (out_push && !out_pop) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end else if (out_pop && !out_push) begin
        out_cnt_q <= out_cnt_q - 1'b1;
      end
    end
  end

  // Color times brightness is fixed for a whole frame: register it at load
  always_ff @(posedge clk_i) begin
    if (frame_pop_o) begin
      desc_q     <= frame_i;
      cb_red_q   <= ProdW'(frame_i.red)   * ProdW'(brightness_i);
      cb_green_q <= ProdW'(frame_i.green) * ProdW'(brightness_i);
      cb_blue_q  <= ProdW'(frame_i.blue)  * ProdW'(brightness_i);
    end
    if (issue) begin
      s1_tail_q <= tail;
      s1_idx_q  <= pix_q;
      s1_last_q <= (pix_q == LastPix);
    end
    if (out_push) begin
      out_grb_q[out_wptr_q]  <= {sc_green[23:16], sc_red[23:16], sc_blue[23:16]};
      out_idx_q[out_wptr_q]  <= s1_idx_q;
      out_last_q[out_wptr_q] <= s1_last_q;
    end
  end

  assign empty         = (out_cnt_q == 2'd0);
  assign pixel_grb_o   = out_grb_q[out_rptr_q];
  assign pixel_index_o = out_idx_q[out_rptr_q];
  assign last_o        = out_last_q[out_rptr_q];

endmodule

@@ rtl/core/led_strip_animation_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_animation_controller_top
// Button stepper, byte command parser and frame renderer for an LED strip.
// ----------------------------------------------------------------------------
// Input queue: drive operation_i, button_level_i and command_byte_i with push;
// a transaction completes on a clock edge with push high and full low.
// Button samples and command bytes update the registered state. A frame tick
// stores a snapshot of the animation state in a two-deep frame queue and
// advances the animation in the same cycle; full rises while both slots hold
// frames that the renderer has not started.
// Result queue: while empty is low the oldest pixel is on pixel_grb_o,
// pixel_index_o and last_o; pop takes it. The renderer produces one pixel per
// cycle while that queue has room and loads a frame only after the previous
// frame's last pixel is issued; pixels pass the snapshot and tail registers
// into the two-entry result queue. A stalled receiver fills it, then the
// renderer and finally the frame queue stop; nothing is dropped. Reset (rst_ni
// low) restores static green, brightness 77, hold 5 frames; it empties both
// queues. Users write registers via cfg_we_i only while idle; it is unchecked.
// ----------------------------------------------------------------------------
module led_strip_animation_controller_top #(
  parameter int unsigned PixelCount = lsac_pkg::DefPixelCount,
  parameter int unsigned TailLength = lsac_pkg::DefTailLength
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                operation_i,
  input  logic                      button_level_i,
  input  logic [7:0]                command_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [23:0]               pixel_grb_o,
  output logic [5:0]                pixel_index_o,
  output logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [lsac_pkg::CfgW-1:0] cfg_data_i
);
  import lsac_pkg::*;

  logic [CfgW-1:0] brightness_q, hold_frames_q;
  logic            frame_push, frame_full, frame_empty, frame_pop;
  frame_t          frame_in, frame_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q  <= BrightnessReset;
      hold_frames_q <= HoldFramesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRIGHTNESS:  brightness_q  <= cfg_data_i;
        CFG_HOLD_FRAMES: hold_frames_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsac_front #(
    .PixelCount(PixelCount)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .button_level_i(button_level_i),
    .command_byte_i(command_byte_i),
    .hold_frames_i (hold_frames_q),
    .frame_push_o  (frame_push),
    .frame_o       (frame_in),
    .frame_full_i  (frame_full)
  );

  lsac_frame_fifo u_frame_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (frame_push),
    .data_i (frame_in),
    .full_o (frame_full),
    .pop_i  (frame_pop),
    .data_o (frame_out),
    .empty_o(frame_empty)
  );

  lsac_back #(
    .PixelCount(PixelCount),
    .TailLength(TailLength)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(!frame_empty),
    .frame_i      (frame_out),
    .frame_pop_o  (frame_pop),
    .brightness_i (brightness_q),
    .empty        (empty),
    .pop          (pop),
    .pixel_grb_o  (pixel_grb_o),
    .pixel_index_o(pixel_index_o),
    .last_o       (last_o)
  );

endmodule
